### sv/aocp_pkg.sv
// ============================================================================
// aocp_pkg : shared types and constants for the ASCII output command parser
// Transfer types, parse mode and number phase codes, and character constants.
// ============================================================================
`default_nettype none

package aocp_pkg;

    localparam int DIGITAL_CHANNELS_DEF = 8;
    localparam int ANALOG_CHANNELS_DEF  = 2;
    localparam int COUNTER_CHANNELS_DEF = 2;

    localparam int DIGITAL_WIDTH = 8;
    localparam int ANALOG_WIDTH  = 12;
    localparam int CLEAR_WIDTH   = 2;
    localparam int INDEX_WIDTH   = 3;
    localparam int NUMBER_WIDTH  = 13;

    localparam logic [NUMBER_WIDTH-1:0] NUMBER_MAX   = 13'd8191;
    localparam logic [NUMBER_WIDTH-1:0] ANALOG_LIMIT = 13'd4096;
    localparam logic [NUMBER_WIDTH-1:0] DIGITAL_LIMIT = 13'd2;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CRET  = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_D     = 8'h44;
    localparam logic [7:0] CHAR_O     = 8'h4F;
    localparam logic [7:0] CHAR_R     = 8'h52;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_DO,
        MODE_AO,
        MODE_CR
    } mode_t;

    typedef enum logic [1:0] {
        PH_LEADING,
        PH_SIGN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [1:0]              length;
        logic [7:0]              first_char;
        logic [7:0]              second_char;
        phase_t                  phase;
        logic                    negative;
        logic [NUMBER_WIDTH-1:0] value;
    } token_t;

    localparam token_t TOKEN_CLEAR = '{
        length:      2'd0,
        first_char:  8'd0,
        second_char: 8'd0,
        phase:       PH_LEADING,
        negative:    1'b0,
        value:       13'd0
    };

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_report;
    } item_t;

    typedef struct packed {
        logic [DIGITAL_WIDTH-1:0] digital_pins;
        logic [ANALOG_WIDTH-1:0]  analog_word_zero;
        logic [ANALOG_WIDTH-1:0]  analog_word_one;
        logic [CLEAR_WIDTH-1:0]   counter_clear;
        logic                     pins_updated;
    } result_t;

endpackage

`default_nettype wire

### sv/aocp_token.sv
// ============================================================================
// aocp_token : token character update
// Records the first two characters and reads the token as an atoi number.
// ============================================================================
`default_nettype none

module aocp_token
    import aocp_pkg::*;
(
    input  token_t     cur,
    input  logic [7:0] ch,
    output token_t     nxt
);

    logic                      is_space;
    logic                      is_sign;
    logic                      is_digit;
    logic [NUMBER_WIDTH+3:0]   scaled;

    assign is_space = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CRET));
    assign is_sign  = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

    // value * 10 + digit
    assign scaled = {1'b0, cur.value, 3'b000} + {3'b000, cur.value, 1'b0}
                  + (NUMBER_WIDTH+4)'(ch - CHAR_ZERO);

    always_comb
    begin
        nxt = cur;
        if (cur.length == 2'd0)
        begin
            nxt.first_char = ch;
        end
        else if (cur.length == 2'd1)
        begin
            nxt.second_char = ch;
        end
        if (cur.length != 2'd3)
        begin
            nxt.length = cur.length + 2'd1;
        end

        priority if ((cur.phase == PH_LEADING) && is_space)
        begin
        end
        else if ((cur.phase == PH_LEADING) && is_sign)
        begin
            nxt.negative = (ch == CHAR_MINUS);
            nxt.phase    = PH_SIGN;
        end
        else if (cur.phase != PH_DONE)
        begin
            if (is_digit)
            begin
                nxt.value = (scaled > (NUMBER_WIDTH+4)'(NUMBER_MAX)) ? NUMBER_MAX
                                                                    : scaled[NUMBER_WIDTH-1:0];
                nxt.phase = PH_DIGITS;
            end
            else
            begin
                nxt.phase = PH_DONE;
            end
        end
        else
        begin
        end
    end

endmodule

`default_nettype wire

### sv/ascii_output_command_parser_core.sv
// ============================================================================
// ascii_output_command_parser_core : report payload command parser
// Splits the payload into comma tokens, selects DO/AO/CR modes, writes the
// digital and analog shadows and drives them out at the end of each report.
// ============================================================================
// Usage
//   item channel   : one payload byte per transfer, end_of_report on the last.
//   result channel : exactly one result per byte, in order; it carries the
//                    driven pin levels, the counter clear pulse caused by that
//                    byte, and pins_updated on the byte that ended a report.
//   Order          : an item passes the input register, then the result
//                    register, before its result is valid.
//   Throughput     : one byte per cycle unless stalled; all token, number and
//                    shadow updates are done in one pass between registers.
//   Stall          : item_stall rises only while the result register is full
//                    and result_stall is high; the pipeline then holds.
//   Reset          : mode none, index zero, token cleared, shadows and driven
//                    outputs zero; no result is pending.
// ============================================================================
`default_nettype none

module ascii_output_command_parser_core
    import aocp_pkg::*;
#(
    parameter int DIGITAL_CHANNELS = DIGITAL_CHANNELS_DEF,
    parameter int ANALOG_CHANNELS  = ANALOG_CHANNELS_DEF,
    parameter int COUNTER_CHANNELS = COUNTER_CHANNELS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [INDEX_WIDTH-1:0] DIG_LAST = INDEX_WIDTH'(DIGITAL_CHANNELS - 1);
    localparam logic [INDEX_WIDTH-1:0] ANA_LAST = INDEX_WIDTH'(ANALOG_CHANNELS - 1);
    localparam logic [INDEX_WIDTH-1:0] DIG_CNT  = INDEX_WIDTH'(DIGITAL_CHANNELS);
    localparam logic [INDEX_WIDTH-1:0] ANA_CNT  = INDEX_WIDTH'(ANALOG_CHANNELS);
    localparam logic [DIGITAL_WIDTH-1:0] DIG_MASK =
        DIGITAL_WIDTH'((1 << DIGITAL_CHANNELS) - 1);
    localparam int ANA_ONE = (ANALOG_CHANNELS > 1) ? 1 : 0;

    logic                     stage_valid_reg;
    item_t                    stage_item_reg;
    logic                     result_valid_reg;
    result_t                  result_reg;
    result_t                  result_next;

    mode_t                    mode_reg,    mode_next;
    logic [INDEX_WIDTH-1:0]   index_reg,   index_next;
    token_t                   token_reg,   token_next;
    logic                     ended_reg,   ended_next;
    logic [DIGITAL_WIDTH-1:0] dshadow_reg, dshadow_next;
    logic [DIGITAL_WIDTH-1:0] ddriven_reg, ddriven_next;
    logic [ANALOG_WIDTH-1:0]  ashadow_reg  [ANALOG_CHANNELS];
    logic [ANALOG_WIDTH-1:0]  ashadow_next [ANALOG_CHANNELS];
    logic [ANALOG_WIDTH-1:0]  adriven_reg  [ANALOG_CHANNELS];
    logic [ANALOG_WIDTH-1:0]  adriven_next [ANALOG_CHANNELS];

    logic                     advance;
    logic                     last;
    logic                     is_nul;
    logic                     is_comma;
    logic                     take;
    logic                     fire;
    token_t                   taken;
    token_t                   tok;
    logic                     kw_do, kw_ao, kw_cr;
    logic                     neg;
    logic [NUMBER_WIDTH-1:0]  v;
    logic [INDEX_WIDTH-1:0]   dig_idx;
    logic [INDEX_WIDTH-1:0]   ana_idx;
    logic [CLEAR_WIDTH-1:0]   pulse;

    assign advance      = !result_valid_reg || !result_stall;
    assign item_stall   = !advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign last     = stage_item_reg.end_of_report;
    assign is_nul   = (stage_item_reg.payload_byte == CHAR_NUL);
    assign is_comma = (stage_item_reg.payload_byte == CHAR_COMMA);
    assign take     = !ended_reg && !is_nul && !is_comma;

    aocp_token u_token
    (
        .cur (token_reg),
        .ch  (stage_item_reg.payload_byte),
        .nxt (taken)
    );

    assign tok  = take ? taken : token_reg;
    assign fire = !ended_reg && (is_nul || is_comma || last) && (tok.length != 2'd0);

    assign kw_do = (tok.length == 2'd2) && (tok.first_char == CHAR_D)
                && (tok.second_char == CHAR_O);
    assign kw_ao = (tok.length == 2'd2) && (tok.first_char == CHAR_A)
                && (tok.second_char == CHAR_O);
    assign kw_cr = (tok.length == 2'd2) && (tok.first_char == CHAR_C)
                && (tok.second_char == CHAR_R);
    assign v     = tok.value;
    assign neg   = tok.negative && (tok.value != '0);

    assign dig_idx = (index_reg > DIG_LAST) ? (index_reg - DIG_CNT) : index_reg;
    assign ana_idx = (index_reg > ANA_LAST) ? (index_reg - ANA_CNT) : index_reg;

    always_comb
    begin
        mode_next    = mode_reg;
        index_next   = index_reg;
        dshadow_next = dshadow_reg;
        ashadow_next = ashadow_reg;
        pulse        = '0;
        if (fire)
        begin
            priority if (kw_do)
            begin
                mode_next  = MODE_DO;
                index_next = '0;
            end
            else if (kw_ao)
            begin
                mode_next  = MODE_AO;
                index_next = '0;
            end
            else if (kw_cr)
            begin
                mode_next = MODE_CR;
            end
            else if (!neg)
            begin
                unique case (mode_reg)
                    MODE_DO:
                    begin
                        index_next = dig_idx;
                        if (v < DIGITAL_LIMIT)
                        begin
                            dshadow_next[dig_idx] = v[0];
                            index_next = (dig_idx == DIG_LAST) ? '0 : dig_idx + 1'b1;
                        end
                    end
                    MODE_AO:
                    begin
                        index_next = ana_idx;
                        if (v < ANALOG_LIMIT)
                        begin
                            for (int j = 0; j < ANALOG_CHANNELS; j++)
                            begin
                                if (ana_idx == INDEX_WIDTH'(j))
                                begin
                                    ashadow_next[j] = v[ANALOG_WIDTH-1:0];
                                end
                            end
                            index_next = (ana_idx == ANA_LAST) ? '0 : ana_idx + 1'b1;
                        end
                    end
                    MODE_CR:
                    begin
                        for (int k = 0; k < CLEAR_WIDTH; k++)
                        begin
                            if ((k < COUNTER_CHANNELS) && (v == NUMBER_WIDTH'(k)))
                            begin
                                pulse[k] = 1'b1;
                            end
                        end
                    end
                    MODE_NONE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
            end
        end
        if (last)
        begin
            index_next = '0;
        end
    end

    always_comb
    begin
        token_next   = (last || fire) ? TOKEN_CLEAR : tok;
        ended_next   = last ? 1'b0 : (ended_reg || is_nul);
        ddriven_next = last ? (dshadow_next & DIG_MASK) : ddriven_reg;
        if (last)
        begin
            adriven_next = ashadow_next;
        end
        else
        begin
            adriven_next = adriven_reg;
        end

        result_next.digital_pins     = ddriven_next;
        result_next.analog_word_zero = adriven_next[0];
        result_next.analog_word_one  = (ANALOG_CHANNELS > 1) ? adriven_next[ANA_ONE] : '0;
        result_next.counter_clear    = pulse;
        result_next.pins_updated     = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_reg         <= MODE_NONE;
            index_reg        <= '0;
            token_reg        <= TOKEN_CLEAR;
            ended_reg        <= 1'b0;
            dshadow_reg      <= '0;
            ddriven_reg      <= '0;
            for (int j = 0; j < ANALOG_CHANNELS; j++)
            begin
                ashadow_reg[j] <= '0;
                adriven_reg[j] <= '0;
            end
        end
        else if (advance)
        begin
            stage_valid_reg  <= item_valid;
            result_valid_reg <= stage_valid_reg;
            if (stage_valid_reg)
            begin
                mode_reg    <= mode_next;
                index_reg   <= index_next;
                token_reg   <= token_next;
                ended_reg   <= ended_next;
                dshadow_reg <= dshadow_next;
                ddriven_reg <= ddriven_next;
                ashadow_reg <= ashadow_next;
                adriven_reg <= adriven_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && item_valid)
        begin
            stage_item_reg <= item;
        end
        if (advance && stage_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

endmodule

`default_nettype wire

### sv/aocp_checker.sv
// ============================================================================
// aocp_checker : port-level checks for the command parser
// Watches the item and result channels of the top level; bound to it below.
// ============================================================================
`default_nettype none

module aocp_checker
    import aocp_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_stall,
    input wire item_t   item,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_stall |=> item_valid && $stable(item))
        else $error("item changed while stalled");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("item stalled without a blocked result");

    a_clear_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $onehot0(result.counter_clear))
        else $error("more than one counter clear in a result");

    a_pins_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall) ##1 (result_valid && !result.pins_updated)
        |-> $stable(result.digital_pins) && $stable(result.analog_word_zero)
            && $stable(result.analog_word_one))
        else $error("driven outputs changed outside a report end");

endmodule

bind ascii_output_command_parser_core aocp_checker u_aocp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

`default_nettype wire

### test/aocp_pin_checker.sv
// ============================================================================
// aocp_pin_checker : result checker for the ASCII output command parser
// Watches both channels, forecasts the pin state for every accepted byte from
// its own copy of the parser and compares each result transfer field by field.
// ============================================================================

module aocp_pin_checker
    import aocp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  logic    item_stall,
    input  item_t   item,
    input  logic    result_valid,
    input  logic    result_stall,
    input  result_t result,
    output int      failures,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    mode_t                    mode;
    logic [INDEX_WIDTH-1:0]   slot;
    token_t                   tok;
    logic                     text_done;
    logic [DIGITAL_WIDTH-1:0] dig_shadow;
    logic [DIGITAL_WIDTH-1:0] dig_driven;
    logic [ANALOG_WIDTH-1:0]  ana_shadow [ANALOG_CHANNELS_DEF];
    logic [ANALOG_WIDTH-1:0]  ana_driven [ANALOG_CHANNELS_DEF];
    result_t                  pin_forecast [$];

    task automatic absorb(input logic [7:0] c);
        int acc;
        if (tok.length == 2'd0)
            tok.first_char = c;
        else if (tok.length == 2'd1)
            tok.second_char = c;
        if (tok.length != 2'd3)
            tok.length = tok.length + 2'd1;

        if (tok.phase == PH_LEADING) begin
            if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CRET))
                return;
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                tok.negative = (c == CHAR_MINUS);
                tok.phase = PH_SIGN;
                return;
            end
        end
        if (tok.phase != PH_DONE) begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                acc = int'(tok.value) * 10 + int'(c - CHAR_ZERO);
                tok.value = (acc > NUMBER_MAX) ? NUMBER_MAX : NUMBER_WIDTH'(acc);
                tok.phase = PH_DIGITS;
            end
            else
                tok.phase = PH_DONE;
        end
    endtask

    task automatic close_token(output logic [CLEAR_WIDTH-1:0] pulse);
        logic [NUMBER_WIDTH-1:0] v;
        pulse = '0;
        v = tok.value;
        if (tok.length == 2'd0)
            return;
        if (tok.length == 2'd2 && tok.first_char == CHAR_D && tok.second_char == CHAR_O) begin
            mode = MODE_DO;
            slot = '0;
        end
        else if (tok.length == 2'd2 && tok.first_char == CHAR_A && tok.second_char == CHAR_O)
        begin
            mode = MODE_AO;
            slot = '0;
        end
        else if (tok.length == 2'd2 && tok.first_char == CHAR_C && tok.second_char == CHAR_R)
        begin
            mode = MODE_CR;
        end
        else if (tok.negative && v != '0) begin
            // negative values other than zero are dropped
        end
        else begin
            case (mode)
                MODE_DO:
                begin
                    if (v < DIGITAL_LIMIT) begin
                        dig_shadow[slot] = v[0];
                        slot = slot + 1'b1;
                    end
                end
                MODE_AO:
                begin
                    slot = INDEX_WIDTH'(slot % ANALOG_CHANNELS_DEF);
                    if (v < ANALOG_LIMIT) begin
                        ana_shadow[slot] = v[ANALOG_WIDTH-1:0];
                        slot = INDEX_WIDTH'((slot + 1) % ANALOG_CHANNELS_DEF);
                    end
                end
                MODE_CR:
                begin
                    if (v < COUNTER_CHANNELS_DEF)
                        pulse = CLEAR_WIDTH'(1) << v;
                end
                default:
                begin
                end
            endcase
        end
        tok = TOKEN_CLEAR;
    endtask

    task automatic parse_byte(input item_t it, output result_t res);
        logic [CLEAR_WIDTH-1:0] pulse;
        logic [CLEAR_WIDTH-1:0] tail;
        pulse = '0;
        tail = '0;
        if (!text_done) begin
            if (it.payload_byte == CHAR_NUL) begin
                close_token(pulse);
                text_done = 1'b1;
            end
            else if (it.payload_byte == CHAR_COMMA)
                close_token(pulse);
            else
                absorb(it.payload_byte);
        end
        if (it.end_of_report) begin
            if (!text_done)
                close_token(tail);
            pulse = pulse | tail;
            dig_driven = dig_shadow;
            ana_driven = ana_shadow;
            slot = '0;
            text_done = 1'b0;
            tok = TOKEN_CLEAR;
        end
        res.digital_pins     = dig_driven;
        res.analog_word_zero = ana_driven[0];
        res.analog_word_one  = ana_driven[1];
        res.counter_clear    = pulse;
        res.pins_updated     = it.end_of_report;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            failures++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        result_t want;
        if (!rst_n) begin
            mode = MODE_NONE;
            slot = '0;
            tok = TOKEN_CLEAR;
            text_done = 1'b0;
            dig_shadow = '0;
            dig_driven = '0;
            foreach (ana_shadow[j]) begin
                ana_shadow[j] = '0;
                ana_driven[j] = '0;
            end
            pin_forecast.delete();
            failures = 0;
            pending = 0;
        end
        else begin
            if (item_valid && !item_stall) begin
                parse_byte(item, want);
                pin_forecast.push_back(want);
            end
            if (result_valid && !result_stall) begin
                if (pin_forecast.size() == 0) begin
                    failures++;
                    $display("%0t ns: unexpected result transfer, expected none, got %p",
                             $time, result);
                end
                else begin
                    want = pin_forecast.pop_front();
                    check_field("digital_pins", want.digital_pins, result.digital_pins);
                    check_field("analog_word_zero", want.analog_word_zero,
                                result.analog_word_zero);
                    check_field("analog_word_one", want.analog_word_one,
                                result.analog_word_one);
                    check_field("counter_clear", want.counter_clear, result.counter_clear);
                    check_field("pins_updated", want.pins_updated, result.pins_updated);
                end
            end
            pending = pin_forecast.size();
        end
    end

endmodule

### test/tb_ascii_output_command_parser_core.sv
// ============================================================================
// tb_ascii_output_command_parser_core : testbench for the command parser
// Sends directed then random reports byte by byte with random gaps and result
// back-pressure; the pin checker forecasts and compares every result.
// ============================================================================

module tb_ascii_output_command_parser_core;
    timeunit 1ns;
    timeprecision 1ps;

    import aocp_pkg::*;

    localparam int RANDOM_BYTES = 1850;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int LONG_HOLD    = 60;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;
    int      failures;
    int      pending;
    int      cycles = 0;
    int      bytes_sent = 0;
    bit      calm = 1'b0;
    bit      hold_req = 1'b0;
    logic [7:0] report_q [$];

    ascii_output_command_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    aocp_pin_checker pin_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .failures     (failures),
        .pending      (pending)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 13);
    endfunction

    task automatic offer(input item_t it, input int gap);
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic load_text(input string s);
        for (int i = 0; i < s.len(); i++)
            report_q.push_back(s[i]);
    endtask

    task automatic send_report(input bit burst);
        item_t it;
        foreach (report_q[i]) begin
            it.payload_byte = report_q[i];
            it.end_of_report = (i == report_q.size() - 1);
            offer(it, burst ? 0 : draw_gap());
            bytes_sent++;
        end
        report_q.delete();
    endtask

    task automatic add_token();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            case ($urandom_range(0, 2))
                0: load_text("DO");
                1: load_text("AO");
                default: load_text("CR");
            endcase
        end
        else if (pick < 80) begin
            if ($urandom_range(0, 4) == 0)
                report_q.push_back($urandom_range(0, 3) == 0 ? CHAR_SPACE
                                   : 8'($urandom_range(CHAR_TAB, CHAR_CRET)));
            case ($urandom_range(0, 9))
                0: report_q.push_back(CHAR_MINUS);
                1: report_q.push_back(CHAR_PLUS);
                default:
                begin
                end
            endcase
            if ($urandom_range(0, 9) == 0)
                report_q.push_back(CHAR_ZERO);
            case ($urandom_range(0, 5))
                0, 1: v = $urandom_range(0, 1);
                2: v = $urandom_range(0, 4095);
                3: v = $urandom_range(4090, 4101);
                4: v = $urandom_range(2, 9);
                default: v = $urandom_range(8000, 99999);
            endcase
            load_text($sformatf("%0d", v));
            if ($urandom_range(0, 7) == 0)
                report_q.push_back(8'($urandom_range(CHAR_SPACE, 8'h7E)));
        end
        else if (pick < 92) begin
            // near misses of the mode tokens
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 4))
                    0: report_q.push_back(CHAR_A);
                    1: report_q.push_back(CHAR_C);
                    2: report_q.push_back(CHAR_D);
                    3: report_q.push_back(CHAR_O);
                    default: report_q.push_back(CHAR_R);
                endcase
            end
        end
        else begin
            repeat ($urandom_range(1, 4))
                report_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic build_report(input int tokens);
        if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 8))
                report_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 9) == 0)
            report_q.push_back(CHAR_COMMA);
        for (int k = 0; k < tokens; k++) begin
            if (k > 0) begin
                report_q.push_back(CHAR_COMMA);
                if ($urandom_range(0, 9) == 0)
                    report_q.push_back(CHAR_COMMA);
            end
            add_token();
        end
        if ($urandom_range(0, 12) == 0) begin
            report_q.push_back(CHAR_NUL);
            repeat ($urandom_range(0, 4))
                report_q.push_back(8'($urandom_range(0, 255)));
        end
        else if ($urandom_range(0, 9) == 0)
            report_q.push_back(CHAR_COMMA);
        if (report_q.size() == 0)
            report_q.push_back(CHAR_COMMA);
    endtask

    // result side back-pressure
    initial begin : drain
        int hold;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold = LONG_HOLD;
                hold_req = 1'b0;
            end
            else
                hold = draw_gap();
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
        end
    end

    initial begin : stimulus
        int reports;
        int directed;
        reports = 0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // empty token, negative value, out of range, whitespace, sign, zero byte
        load_text("DO,1,-1");
        send_report(1'b0);
        load_text("AO,4096,");
        report_q.push_back(CHAR_TAB);
        load_text("+7");
        send_report(1'b0);
        load_text("CR,,0");
        report_q.push_back(CHAR_NUL);
        report_q.push_back(8'hFF);
        send_report(1'b0);
        directed = bytes_sent;
        wait_idle();

        while (bytes_sent < directed + RANDOM_BYTES) begin
            calm = ($urandom_range(0, 5) == 0);
            if (reports == 30) begin
                hold_req = 1'b1;
                build_report(12);
                send_report(1'b1);
            end
            else begin
                build_report($urandom_range(1, 6));
                send_report(1'b0);
            end
            if (reports == 70)
                wait_idle();
            reports++;
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
sv/aocp_pkg.sv
sv/aocp_token.sv
sv/ascii_output_command_parser_core.sv
sv/aocp_checker.sv
test/aocp_pin_checker.sv
test/tb_ascii_output_command_parser_core.sv
